// ----- sv/aat_pkg.sv -----
`default_nettype none

package aat_pkg;

  // Fixed field formats
  localparam int unsigned COORD_WIDTH = 32;  // signed Q16.16 coordinates
  localparam int unsigned COEF_WIDTH  = 16;  // signed Q2.14 coefficients
  localparam int unsigned COEF_FRAC   = 14;
  localparam int unsigned NUM_AXES    = 3;
  localparam int unsigned ROW_WIDTH   = NUM_AXES * COEF_WIDTH;

  // Configuration bus
  localparam int unsigned APB_DATA_WIDTH = 64;
  localparam int unsigned APB_ADDR_WIDTH = 6;   // six registers at 8 byte stride
  localparam int unsigned REG_IDX_LSB    = 3;
  localparam int unsigned REG_IDX_WIDTH  = APB_ADDR_WIDTH - REG_IDX_LSB;

  typedef enum logic [REG_IDX_WIDTH-1:0] {
    REG_COEF_ROW_X = 3'd0,
    REG_COEF_ROW_Y = 3'd1,
    REG_COEF_ROW_Z = 3'd2,
    REG_SHIFT_X    = 3'd3,
    REG_SHIFT_Y    = 3'd4,
    REG_SHIFT_Z    = 3'd5
  } reg_idx_e;

  // Reset transform is the identity
  localparam logic [ROW_WIDTH-1:0] COEF_ONE = ROW_WIDTH'(1) << COEF_FRAC;
  localparam logic [ROW_WIDTH-1:0] COEF_ROW_X_RST = COEF_ONE;
  localparam logic [ROW_WIDTH-1:0] COEF_ROW_Y_RST = COEF_ONE << COEF_WIDTH;
  localparam logic [ROW_WIDTH-1:0] COEF_ROW_Z_RST = COEF_ONE << (2 * COEF_WIDTH);

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] in_min_x;
    logic signed [COORD_WIDTH-1:0] in_min_y;
    logic signed [COORD_WIDTH-1:0] in_min_z;
    logic signed [COORD_WIDTH-1:0] in_max_x;
    logic signed [COORD_WIDTH-1:0] in_max_y;
    logic signed [COORD_WIDTH-1:0] in_max_z;
  } box_in_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] out_min_x;
    logic signed [COORD_WIDTH-1:0] out_min_y;
    logic signed [COORD_WIDTH-1:0] out_min_z;
    logic signed [COORD_WIDTH-1:0] out_max_x;
    logic signed [COORD_WIDTH-1:0] out_max_y;
    logic signed [COORD_WIDTH-1:0] out_max_z;
  } box_out_t;

endpackage

`default_nettype wire

// ----- sv/aabb_affine_transform_core.sv -----
`default_nettype none

// Affine transform of an axis-aligned box: bounding box of the mapped box.
//
// Request channel: box_i is taken at a rising edge with start_i high and
// busy_o low. busy_o is always low, so a new box can enter every cycle.
// Result channel: box_o is valid for exactly one cycle while done_o is high;
// there is no backpressure, results leave in request order.
// Pipeline stages from the accepting edge to done_o high: multiply,
// floor-shift and min/max pick, sum, saturate; throughput is one
// box per cycle, set by the 18 parallel 16x32 multipliers of the first stage.
// Configuration: 64-bit APB-style port, register i at byte address 8*i
// (coefficient rows x,y,z then translations x,y,z); pready is always high.
// Registers may only be written while no request is in flight.
// Reset: pipeline emptied, transform set to identity with zero translation.

module aabb_affine_transform_core (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  // request / result
  input  wire logic                                   start_i,
  output logic                                        busy_o,
  input  wire aat_pkg::box_in_t                       box_i,
  output logic                                        done_o,
  output aat_pkg::box_out_t                           box_o,
  // configuration
  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic [aat_pkg::APB_ADDR_WIDTH-1:0]     paddr,
  input  wire logic [aat_pkg::APB_DATA_WIDTH-1:0]     pwdata,
  output logic [aat_pkg::APB_DATA_WIDTH-1:0]          prdata,
  output logic                                        pready
);

  localparam int unsigned CW     = aat_pkg::COORD_WIDTH;
  localparam int unsigned KW     = aat_pkg::COEF_WIDTH;
  localparam int unsigned NA     = aat_pkg::NUM_AXES;
  localparam int unsigned RW     = aat_pkg::ROW_WIDTH;
  localparam int unsigned DW     = aat_pkg::APB_DATA_WIDTH;
  localparam int unsigned PROD_W = CW + KW;
  localparam int unsigned PICK_W = PROD_W - aat_pkg::COEF_FRAC;
  localparam int unsigned SUM_W  = PICK_W + 2;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'({1'b0, {(CW-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [RW-1:0]        coef_row_q [NA];
  logic signed [CW-1:0] shift_q    [NA];
  logic                 cfg_wr;
  aat_pkg::reg_idx_e    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = aat_pkg::reg_idx_e'(paddr[aat_pkg::APB_ADDR_WIDTH-1:aat_pkg::REG_IDX_LSB]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_row_q[0] <= aat_pkg::COEF_ROW_X_RST;
      coef_row_q[1] <= aat_pkg::COEF_ROW_Y_RST;
      coef_row_q[2] <= aat_pkg::COEF_ROW_Z_RST;
      shift_q[0]    <= '0;
      shift_q[1]    <= '0;
      shift_q[2]    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        aat_pkg::REG_COEF_ROW_X: coef_row_q[0] <= pwdata[RW-1:0];
        aat_pkg::REG_COEF_ROW_Y: coef_row_q[1] <= pwdata[RW-1:0];
        aat_pkg::REG_COEF_ROW_Z: coef_row_q[2] <= pwdata[RW-1:0];
        aat_pkg::REG_SHIFT_X:    shift_q[0]    <= pwdata[CW-1:0];
        aat_pkg::REG_SHIFT_Y:    shift_q[1]    <= pwdata[CW-1:0];
        aat_pkg::REG_SHIFT_Z:    shift_q[2]    <= pwdata[CW-1:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (cfg_idx)
      aat_pkg::REG_COEF_ROW_X: prdata = DW'(coef_row_q[0]);
      aat_pkg::REG_COEF_ROW_Y: prdata = DW'(coef_row_q[1]);
      aat_pkg::REG_COEF_ROW_Z: prdata = DW'(coef_row_q[2]);
      aat_pkg::REG_SHIFT_X:    prdata = DW'(unsigned'(shift_q[0]));
      aat_pkg::REG_SHIFT_Y:    prdata = DW'(unsigned'(shift_q[1]));
      aat_pkg::REG_SHIFT_Z:    prdata = DW'(unsigned'(shift_q[2]));
      default:                 prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Request side: never stalls
  // ---------------------------------------------------------------------------
  logic                 req_acc;
  logic signed [CW-1:0] in_min [NA];
  logic signed [CW-1:0] in_max [NA];

  assign busy_o  = 1'b0;
  assign req_acc = start_i & ~busy_o;

  assign in_min[0] = box_i.in_min_x;
  assign in_min[1] = box_i.in_min_y;
  assign in_min[2] = box_i.in_min_z;
  assign in_max[0] = box_i.in_max_x;
  assign in_max[1] = box_i.in_max_y;
  assign in_max[2] = box_i.in_max_z;

  // Valid bits for stages 1..4
  logic [3:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], req_acc};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: products c(j,i) * min_j and c(j,i) * max_j, index [out i][in j]
  // ---------------------------------------------------------------------------
  logic signed [PROD_W-1:0] prod_mn_d [NA][NA];
  logic signed [PROD_W-1:0] prod_mx_d [NA][NA];
  logic signed [PROD_W-1:0] prod_mn_q [NA][NA];
  logic signed [PROD_W-1:0] prod_mx_q [NA][NA];

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NA; j++) begin
        prod_mn_d[i][j] = PROD_W'(signed'(coef_row_q[j][i*KW +: KW])) * PROD_W'(in_min[j]);
        prod_mx_d[i][j] = PROD_W'(signed'(coef_row_q[j][i*KW +: KW])) * PROD_W'(in_max[j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      prod_mn_q <= prod_mn_d;
      prod_mx_q <= prod_mx_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: floor shift, then send the smaller term to min and larger to max
  // ---------------------------------------------------------------------------
  logic signed [PICK_W-1:0] pick_lo_d [NA][NA];
  logic signed [PICK_W-1:0] pick_hi_d [NA][NA];
  logic signed [PICK_W-1:0] pick_lo_q [NA][NA];
  logic signed [PICK_W-1:0] pick_hi_q [NA][NA];

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NA; j++) begin
        // arithmetic right shift rounds toward minus infinity
        logic signed [PICK_W-1:0] a;
        logic signed [PICK_W-1:0] b;
        a = PICK_W'(prod_mn_q[i][j] >>> aat_pkg::COEF_FRAC);
        b = PICK_W'(prod_mx_q[i][j] >>> aat_pkg::COEF_FRAC);
        if (a < b) begin
          pick_lo_d[i][j] = a;
          pick_hi_d[i][j] = b;
        end else begin
          pick_lo_d[i][j] = b;
          pick_hi_d[i][j] = a;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q[0]) begin
      pick_lo_q <= pick_lo_d;
      pick_hi_q <= pick_hi_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: exact sum of translation and three terms per output axis
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0] sum_lo_d [NA];
  logic signed [SUM_W-1:0] sum_hi_d [NA];
  logic signed [SUM_W-1:0] sum_lo_q [NA];
  logic signed [SUM_W-1:0] sum_hi_q [NA];

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      sum_lo_d[i] = SUM_W'(shift_q[i]) + SUM_W'(pick_lo_q[i][0])
                  + SUM_W'(pick_lo_q[i][1]) + SUM_W'(pick_lo_q[i][2]);
      sum_hi_d[i] = SUM_W'(shift_q[i]) + SUM_W'(pick_hi_q[i][0])
                  + SUM_W'(pick_hi_q[i][1]) + SUM_W'(pick_hi_q[i][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q[1]) begin
      sum_lo_q <= sum_lo_d;
      sum_hi_q <= sum_hi_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: saturate to coordinate range, output register
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] sat_lo [NA];
  logic signed [CW-1:0] sat_hi [NA];
  aat_pkg::box_out_t    box_d;
  aat_pkg::box_out_t    box_q;

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      if (sum_lo_q[i] > SAT_HI)      sat_lo[i] = SAT_HI[CW-1:0];
      else if (sum_lo_q[i] < SAT_LO) sat_lo[i] = SAT_LO[CW-1:0];
      else                           sat_lo[i] = sum_lo_q[i][CW-1:0];
      if (sum_hi_q[i] > SAT_HI)      sat_hi[i] = SAT_HI[CW-1:0];
      else if (sum_hi_q[i] < SAT_LO) sat_hi[i] = SAT_LO[CW-1:0];
      else                           sat_hi[i] = sum_hi_q[i][CW-1:0];
    end
    box_d.out_min_x = sat_lo[0];
    box_d.out_min_y = sat_lo[1];
    box_d.out_min_z = sat_lo[2];
    box_d.out_max_x = sat_hi[0];
    box_d.out_max_y = sat_hi[1];
    box_d.out_max_z = sat_hi[2];
  end

  always_ff @(posedge clk_i) begin
    if (vld_q[2]) begin
      box_q <= box_d;
    end
  end

  assign done_o = vld_q[3];
  assign box_o  = box_q;

endmodule

`default_nettype wire

// ----- tb/aat_box_checker.sv -----
`timescale 1ns / 100ps

// Watches the request, result and register channels of the box transform
// core, predicts every result and compares it field by field.
module aat_box_checker
  import aat_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      busy_i,
  input  box_in_t                   box_i,
  input  logic                      done_i,
  input  box_out_t                  box_res_i,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_WIDTH-1:0] paddr,
  input  logic [APB_DATA_WIDTH-1:0] pwdata,
  input  logic                      pready,
  output int                        err_count_o,
  output int                        open_count_o
);

  localparam int unsigned NUM_FIELDS  = 6;
  localparam int unsigned MAX_REPORTS = 10;

  // Shadow copy of the transform
  logic [ROW_WIDTH-1:0]          coef_row_q [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] shift_q    [NUM_AXES];

  box_out_t    expected_boxes [$];
  int unsigned box_seq;
  string       field_names [NUM_FIELDS] = '{"out_min_x", "out_min_y", "out_min_z",
                                            "out_max_x", "out_max_y", "out_max_z"};

  // Clamp an exact sum to the signed coordinate range
  function automatic logic signed [COORD_WIDTH-1:0] clamp_coord(input longint s);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (s > hi) s = hi;
    if (s < lo) s = lo;
    return s[COORD_WIDTH-1:0];
  endfunction

  // Bounding box of the transformed box (per-axis min/max product pick)
  function automatic box_out_t bound_box(input box_in_t b);
    longint   bmin [NUM_AXES];
    longint   bmax [NUM_AXES];
    longint   lo;
    longint   hi;
    longint   c;
    longint   pa;
    longint   pb;
    logic signed [COORD_WIDTH-1:0] new_min [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] new_max [NUM_AXES];
    box_out_t r;
    bmin[0] = longint'($signed(b.in_min_x));
    bmin[1] = longint'($signed(b.in_min_y));
    bmin[2] = longint'($signed(b.in_min_z));
    bmax[0] = longint'($signed(b.in_max_x));
    bmax[1] = longint'($signed(b.in_max_y));
    bmax[2] = longint'($signed(b.in_max_z));
    for (int i = 0; i < NUM_AXES; i++) begin
      lo = longint'(shift_q[i]);
      hi = lo;
      for (int j = 0; j < NUM_AXES; j++) begin
        c  = longint'($signed(coef_row_q[j][i*COEF_WIDTH +: COEF_WIDTH]));
        // arithmetic shift of the exact product floors toward minus infinity
        pa = (c * bmin[j]) >>> COEF_FRAC;
        pb = (c * bmax[j]) >>> COEF_FRAC;
        if (pa < pb) begin
          lo += pa;
          hi += pb;
        end else begin
          lo += pb;
          hi += pa;
        end
      end
      new_min[i] = clamp_coord(lo);
      new_max[i] = clamp_coord(hi);
    end
    r.out_min_x = new_min[0];
    r.out_min_y = new_min[1];
    r.out_min_z = new_min[2];
    r.out_max_x = new_max[0];
    r.out_max_y = new_max[1];
    r.out_max_z = new_max[2];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    box_out_t                 want;
    logic [REG_IDX_WIDTH-1:0] reg_sel;
    if (!rst_ni) begin
      coef_row_q[0] = COEF_ROW_X_RST;
      coef_row_q[1] = COEF_ROW_Y_RST;
      coef_row_q[2] = COEF_ROW_Z_RST;
      for (int k = 0; k < NUM_AXES; k++) shift_q[k] = '0;
      expected_boxes.delete();
      err_count_o = 0;
      box_seq     = 0;
    end else begin
      // register writes; bits above a register's width are dropped
      if (psel && penable && pwrite && pready) begin
        reg_sel = paddr[REG_IDX_LSB +: REG_IDX_WIDTH];
        case (reg_sel)
          REG_COEF_ROW_X, REG_COEF_ROW_Y, REG_COEF_ROW_Z: begin
            coef_row_q[reg_sel[1:0]] = pwdata[ROW_WIDTH-1:0];
          end
          REG_SHIFT_X, REG_SHIFT_Y, REG_SHIFT_Z: begin
            shift_q[2'(reg_sel - REG_SHIFT_X)] = pwdata[COORD_WIDTH-1:0];
          end
          default: ;  // unmapped index, ignored
        endcase
      end

      // predict each accepted request
      if (start_i && !busy_i) expected_boxes.push_back(bound_box(box_i));

      // compare each result with the oldest prediction
      if (done_i) begin
        if (expected_boxes.size() == 0) begin
          err_count_o++;
          if (err_count_o <= MAX_REPORTS)
            $display("result %0d arrived with no request pending: %h", box_seq, box_res_i);
        end else begin
          want = expected_boxes.pop_front();
          for (int f = 0; f < NUM_FIELDS; f++) begin
            if (box_res_i[(NUM_FIELDS-1-f)*COORD_WIDTH +: COORD_WIDTH] !==
                want[(NUM_FIELDS-1-f)*COORD_WIDTH +: COORD_WIDTH]) begin
              err_count_o++;
              if (err_count_o <= MAX_REPORTS)
                $display("box %0d %s: expected %h, got %h", box_seq, field_names[f],
                         want[(NUM_FIELDS-1-f)*COORD_WIDTH +: COORD_WIDTH],
                         box_res_i[(NUM_FIELDS-1-f)*COORD_WIDTH +: COORD_WIDTH]);
            end
          end
        end
        box_seq++;
      end
    end
    open_count_o = expected_boxes.size();
  end

endmodule

// ----- tb/aabb_affine_transform_core_tb.sv -----
`timescale 1ns / 100ps

module aabb_affine_transform_core_tb;
  import aat_pkg::*;

  localparam int unsigned STALL_LIMIT     = 1000;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned PHASES          = 16;
  localparam int unsigned BOXES_PER_PHASE = 100;
  localparam int unsigned REG_COUNT       = 6;   // first unmapped register index

  localparam logic [COORD_WIDTH-1:0] COORD_MIN = 32'h8000_0000;
  localparam logic [COORD_WIDTH-1:0] COORD_MAX = 32'h7FFF_FFFF;
  localparam logic [COORD_WIDTH-1:0] COORD_NEG = 32'hFFFF_FFFF;

  typedef enum {XF_IDENTITY, XF_NEG_EXTREME, XF_POS_EXTREME, XF_ZERO, XF_RANDOM} xform_e;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      start_i;
  logic                      busy_o;
  box_in_t                   box_i;
  logic                      done_o;
  box_out_t                  box_o;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [APB_ADDR_WIDTH-1:0] paddr;
  logic [APB_DATA_WIDTH-1:0] pwdata;
  logic [APB_DATA_WIDTH-1:0] prdata;
  logic                      pready;
  int                        err_count;
  int                        open_count;
  int unsigned               stall_cycles = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  aabb_affine_transform_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .box_i   (box_i),
    .done_o  (done_o),
    .box_o   (box_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  aat_box_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .box_i        (box_i),
    .done_i       (done_o),
    .box_res_i    (box_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .err_count_o  (err_count),
    .open_count_o (open_count)
  );

  // Watchdog: cycles with no request, result or register write
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o || (psel && penable && pwrite && pready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [COORD_WIDTH-1:0] rand_coord();
    case ($urandom_range(9))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2:       return '0;
      3, 4, 5: return $urandom;
      default: return $unsigned($signed($urandom) >>> $urandom_range(24, 8));
    endcase
  endfunction

  function automatic logic [COEF_WIDTH-1:0] rand_coef();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return '0;
      3:       return 16'h4000;  // +1.0
      4:       return 16'hC000;  // -1.0
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [COORD_WIDTH-1:0] rand_shift();
    case ($urandom_range(5))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2:       return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic box_in_t mk_box(input logic [COORD_WIDTH-1:0] min_x, min_y, min_z,
                                     input logic [COORD_WIDTH-1:0] max_x, max_y, max_z);
    return box_in_t'({min_x, min_y, min_z, max_x, max_y, max_z});
  endfunction

  // Register write: setup cycle, then access cycle until pready
  task automatic cfg_write(input logic [REG_IDX_WIDTH-1:0] idx,
                           input logic [APB_DATA_WIDTH-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_WIDTH'(idx) << REG_IDX_LSB;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Present one request, with random idle cycles ahead of it; entered and left at a negedge
  task automatic push_box(input box_in_t b, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    box_i   <= b;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  // Stop requesting and wait for every outstanding result
  task automatic settle();
    start_i <= 1'b0;
    while (open_count != 0) @(negedge clk_i);
  endtask

  task automatic load_transform(input xform_e mode);
    logic [APB_DATA_WIDTH-1:0] row [NUM_AXES];
    logic [APB_DATA_WIDTH-1:0] sh  [NUM_AXES];
    for (int k = 0; k < NUM_AXES; k++) begin
      case (mode)
        XF_IDENTITY: begin
          row[k] = APB_DATA_WIDTH'(COEF_ONE) << (k * COEF_WIDTH);
          sh[k]  = '0;
        end
        XF_NEG_EXTREME: begin
          row[k] = {16'hFFFF, {NUM_AXES{16'h8000}}};
          sh[k]  = {32'hFFFF_FFFF, COORD_MIN};
        end
        XF_POS_EXTREME: begin
          row[k] = {16'h5A5A, {NUM_AXES{16'h7FFF}}};
          sh[k]  = {32'h0000_0000, COORD_MAX};
        end
        XF_ZERO: begin
          row[k] = {16'($urandom), 48'h0};
          sh[k]  = {$urandom, rand_shift()};
        end
        default: begin
          row[k] = {16'($urandom), rand_coef(), rand_coef(), rand_coef()};
          sh[k]  = {$urandom, rand_shift()};
        end
      endcase
    end
    cfg_write(REG_COEF_ROW_X, row[0]);
    cfg_write(REG_COEF_ROW_Y, row[1]);
    cfg_write(REG_COEF_ROW_Z, row[2]);
    cfg_write(REG_SHIFT_X, sh[0]);
    cfg_write(REG_SHIFT_Y, sh[1]);
    cfg_write(REG_SHIFT_Z, sh[2]);
    // writes to unmapped indexes must leave the transform alone
    if (mode == XF_RANDOM && $urandom_range(2) == 0)
      cfg_write(REG_IDX_WIDTH'(REG_COUNT + $urandom_range(1)), {$urandom, $urandom});
  endtask

  initial begin : stimulus
    xform_e                  mode;
    int                      idle;
    logic [COORD_WIDTH-1:0]  lo [NUM_AXES];
    logic [COORD_WIDTH-1:0]  hi [NUM_AXES];
    logic [COORD_WIDTH-1:0]  tmp;

    rst_ni  = 1'b0;
    start_i = 1'b0;
    box_i   = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // identity transform out of reset: zero box, full range, inverted, degenerate, small box across zero
    push_box(mk_box('0, '0, '0, '0, '0, '0), 6);
    push_box(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX), 6);
    push_box(mk_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN), 6);
    push_box(mk_box(32'h0001_8000, 32'h0001_8000, 32'h0001_8000,
                    32'h0001_8000, 32'h0001_8000, 32'h0001_8000), 6);
    push_box(mk_box(COORD_NEG, COORD_NEG, COORD_NEG, 32'h1, 32'h1, 32'h1), 6);

    // most negative coefficients and translation: saturation both ways
    settle();
    load_transform(XF_NEG_EXTREME);
    push_box(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX), 6);
    push_box(mk_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN), 6);
    push_box(mk_box(32'h1, COORD_NEG, 32'h3, 32'h5, 32'hFFFF_FFFD, 32'h7), 6);

    // most positive coefficients and translation
    settle();
    load_transform(XF_POS_EXTREME);
    push_box(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX), 6);
    push_box(mk_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN), 6);
    push_box(mk_box(32'h4000_0000, 32'hC000_0000, '0, 32'hC000_0000, 32'h4000_0000, '0), 6);

    // mixed-sign small coefficients for floor rounding; junk above register widths
    settle();
    cfg_write(REG_COEF_ROW_X, {16'hFFFF, 16'hC000, 16'h0001, 16'hFFFF});
    cfg_write(REG_COEF_ROW_Y, {16'hFFFF, 16'h2000, 16'hFFFF, 16'h0003});
    cfg_write(REG_COEF_ROW_Z, {16'h1234, 16'h4000, 16'hE000, 16'h7FFF});
    cfg_write(REG_SHIFT_X, {32'hFFFF_FFFF, 32'h0000_8000});
    cfg_write(REG_SHIFT_Y, {32'h8000_0000, 32'hFFFF_0000});
    cfg_write(REG_SHIFT_Z, {32'h7FFF_FFFF, 32'h0000_0001});
    cfg_write(REG_IDX_WIDTH'(REG_COUNT), '1);
    cfg_write(REG_IDX_WIDTH'(REG_COUNT + 1), '1);
    push_box(mk_box(32'hFFFF_FFFD, 32'h5, COORD_NEG, 32'h3, 32'h7, 32'h1), 6);
    push_box(mk_box(32'h3, 32'hFFFF_FFF9, 32'h1, COORD_NEG, 32'h5, 32'hFFFF_FFFB), 6);
    push_box(mk_box(32'h0001_0001, 32'hFFFE_FFFF, 32'h0000_4001,
                    32'h0002_0003, 32'h0000_0001, 32'h0000_C001), 6);

    // zero coefficients: equal products, result is the translation
    settle();
    load_transform(XF_ZERO);
    push_box(mk_box(COORD_MIN, 32'h1234_5678, COORD_NEG, COORD_MAX, 32'h1, '0), 6);
    push_box(mk_box(32'h9, 32'h9, 32'h9, 32'h2, 32'h2, 32'h2), 6);

    // random boxes across a series of transforms and idle rates
    for (int p = 0; p < PHASES; p++) begin
      idle = (p < 6) ? 6 : (p < 11) ? 53 : 0;
      if (p == 0)               mode = XF_NEG_EXTREME;
      else if (p == 1)          mode = XF_POS_EXTREME;
      else if (p == 2)          mode = XF_ZERO;
      else if (p == PHASES - 1) mode = XF_IDENTITY;
      else                      mode = XF_RANDOM;
      settle();
      load_transform(mode);
      repeat (BOXES_PER_PHASE) begin
        // mostly ordered boxes, some degenerate or inverted axes
        for (int k = 0; k < NUM_AXES; k++) begin
          lo[k] = rand_coord();
          hi[k] = ($urandom_range(19) == 0) ? lo[k] : rand_coord();
          if ($urandom_range(9) != 0 && $signed(lo[k]) > $signed(hi[k])) begin
            tmp   = lo[k];
            lo[k] = hi[k];
            hi[k] = tmp;
          end
        end
        push_box(mk_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]), idle);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (err_count == 0 && open_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
